// ----- design/ipid_pkg.sv -----
// Shared types and constants of the incremental PID controller with clamped drive.
package ipid_pkg;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_SETPOINT = 3'd0,
    IDX_KP_GAIN  = 3'd1,
    IDX_KI_GAIN  = 3'd2,
    IDX_KD_GAIN  = 3'd3,
    IDX_OUT_MIN  = 3'd4,
    IDX_OUT_MAX  = 3'd5
  } cfg_idx_t;

  localparam logic [DATA_W-1:0] RST_SETPOINT = 16'd50;
  localparam logic [DATA_W-1:0] RST_KP_GAIN  = 16'd768;
  localparam logic [DATA_W-1:0] RST_KI_GAIN  = 16'd77;
  localparam logic [DATA_W-1:0] RST_KD_GAIN  = 16'd26;
  localparam logic [DATA_W-1:0] RST_OUT_MIN  = 16'd10;
  localparam logic [DATA_W-1:0] RST_OUT_MAX  = 16'd1000;

  typedef struct packed {
    logic [DATA_W-1:0] setpoint;
    logic [DATA_W-1:0] kp_gain;
    logic [DATA_W-1:0] ki_gain;
    logic [DATA_W-1:0] kd_gain;
    logic [DATA_W-1:0] out_min;
    logic [DATA_W-1:0] out_max;
  } cfg_t;

endpackage

// ----- design/incremental_pid_clamped.sv -----
// Top level of the incremental PID controller with clamped drive output.
// A beat passes through the input register, then the drive register.
// Throughput: one beat per cycle while out_tready is high, set by the loop
// that forms error, three gain products and clamp and feeds the drive back.
// Reset (rst_n low, synchronous): configuration registers take their reset
// values, error history and previous drive clear to zero, no beat is held.
module incremental_pid_clamped #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ipid_pkg::DATA_W-1:0]    in_tdata,   // [15:0] measured
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ipid_pkg::DATA_W-1:0]    out_tdata,  // [15:0] drive
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ipid_pkg::DATA_W-1:0]    cfg_wdata
);
  import ipid_pkg::*;

  cfg_t              cfg;
  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [DATA_W-1:0] meas_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              in_beat;
  logic              advance;

  ipid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The sample held in the input register moves into the result stage when
  // the result register is empty or its beat is being taken this cycle.
  // The drive register inside the core is the result register: it only
  // changes on such a move, so it holds steady while a result waits.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_beat) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sample payload carries no reset.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      meas_r <= in_tdata;
    end
  end

  ipid_core #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .meas  (meas_r),
    .cfg   (cfg),
    .drive (out_tdata)
  );

  assign out_tvalid = out_valid_r;

endmodule

// ----- design/ipid_cfg_regs.sv -----
// Configuration register file of the incremental PID controller.
module ipid_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ipid_pkg::DATA_W-1:0]    cfg_wdata,
  output ipid_pkg::cfg_t                 cfg
);
  import ipid_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        IDX_SETPOINT: cfg_nxt.setpoint = cfg_wdata;
        IDX_KP_GAIN:  cfg_nxt.kp_gain  = cfg_wdata;
        IDX_KI_GAIN:  cfg_nxt.ki_gain  = cfg_wdata;
        IDX_KD_GAIN:  cfg_nxt.kd_gain  = cfg_wdata;
        IDX_OUT_MIN:  cfg_nxt.out_min  = cfg_wdata;
        IDX_OUT_MAX:  cfg_nxt.out_max  = cfg_wdata;
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint <= RST_SETPOINT;
      cfg_r.kp_gain  <= RST_KP_GAIN;
      cfg_r.ki_gain  <= RST_KI_GAIN;
      cfg_r.kd_gain  <= RST_KD_GAIN;
      cfg_r.out_min  <= RST_OUT_MIN;
      cfg_r.out_max  <= RST_OUT_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/ipid_core.sv -----
// Error history, PID increment and clamped drive register of the controller.
module ipid_core #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [ipid_pkg::DATA_W-1:0] meas,
  input  ipid_pkg::cfg_t              cfg,
  output logic [ipid_pkg::DATA_W-1:0] drive
);
  import ipid_pkg::*;

  localparam int XW  = (SAMPLE_BITS > DATA_W) ? SAMPLE_BITS : DATA_W;
  localparam int EW  = SAMPLE_BITS + 1;
  localparam int D1W = EW + 1;
  localparam int D2W = EW + 2;
  localparam int GW  = DATA_W + 1;
  localparam int PW  = GW + D2W;
  localparam int SW  = PW + 2;
  localparam int NW  = SW + 1;

  logic [XW-1:0]          sp_x;
  logic [XW-1:0]          meas_x;
  logic [SAMPLE_BITS-1:0] sp_s;
  logic [SAMPLE_BITS-1:0] meas_s;
  logic signed [EW-1:0]   e0_nxt;
  logic signed [EW-1:0]   err_now_r;
  logic signed [EW-1:0]   err_prev_r;
  logic signed [EW-1:0]   err_prev2_r;
  logic signed [D1W-1:0]  d1;
  logic signed [D2W-1:0]  d2;
  logic signed [GW-1:0]   kp_s;
  logic signed [GW-1:0]   ki_s;
  logic signed [GW-1:0]   kd_s;
  logic signed [PW-1:0]   p_term;
  logic signed [PW-1:0]   i_term;
  logic signed [PW-1:0]   d_term;
  logic signed [SW-1:0]   sum;
  logic signed [SW-1:0]   inc;
  logic signed [NW-1:0]   next;
  logic signed [NW-1:0]   lim_max;
  logic signed [NW-1:0]   lim_min;
  logic signed [NW-1:0]   hi_cl;
  logic signed [NW-1:0]   lo_cl;
  logic [DATA_W-1:0]      last_drive_r;
  logic [DATA_W-1:0]      last_drive_nxt;

  // Both operands are reduced to the sample width before the subtract.
  assign sp_x   = XW'(cfg.setpoint);
  assign meas_x = XW'(meas);
  assign sp_s   = sp_x[SAMPLE_BITS-1:0];
  assign meas_s = meas_x[SAMPLE_BITS-1:0];
  assign e0_nxt = $signed({1'b0, sp_s}) - $signed({1'b0, meas_s});

  // The incoming error is e0, the stored newest error becomes e1, and so on.
  assign d1 = D1W'(e0_nxt) - D1W'(err_now_r);
  assign d2 = D2W'(e0_nxt) - (D2W'(err_now_r) <<< 1) + D2W'(err_prev_r);

  assign kp_s = $signed({1'b0, cfg.kp_gain});
  assign ki_s = $signed({1'b0, cfg.ki_gain});
  assign kd_s = $signed({1'b0, cfg.kd_gain});

  assign p_term = PW'(kp_s) * PW'(d1);
  assign i_term = PW'(ki_s) * PW'(e0_nxt);
  assign d_term = PW'(kd_s) * PW'(d2);

  assign sum = SW'(p_term) + SW'(i_term) + SW'(d_term);
  assign inc = sum >>> GAIN_FRAC_BITS;

  assign next    = NW'(inc) + NW'($signed({1'b0, last_drive_r}));
  assign lim_max = NW'($signed({1'b0, cfg.out_max}));
  assign lim_min = NW'($signed({1'b0, cfg.out_min}));

  // Upper bound first, lower bound last, so inverted bounds yield out_min.
  assign hi_cl          = (next > lim_max) ? lim_max : next;
  assign lo_cl          = (hi_cl < lim_min) ? lim_min : hi_cl;
  assign last_drive_nxt = lo_cl[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_now_r    <= '0;
      err_prev_r   <= '0;
      err_prev2_r  <= '0;
      last_drive_r <= '0;
    end else if (step) begin
      err_now_r    <= e0_nxt;
      err_prev_r   <= err_now_r;
      err_prev2_r  <= err_prev_r;
      last_drive_r <= last_drive_nxt;
    end
  end

  assign drive = last_drive_r;

endmodule

// ----- design/ipid_checker.sv -----
// Port-level assertions of the incremental PID controller and their binding.
module ipid_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ipid_pkg::DATA_W-1:0]    out_tdata,
  input logic                           cfg_we,
  input logic [ipid_pkg::CFG_IDX_W-1:0] cfg_addr,
  input logic [ipid_pkg::DATA_W-1:0]    cfg_wdata
);
  import ipid_pkg::*;

  logic [DATA_W-1:0] min_r;
  logic [DATA_W-1:0] max_r;

  // Shadow copies of the clamp bounds, taken from the write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= RST_OUT_MIN;
      max_r <= RST_OUT_MAX;
    end else if (cfg_we) begin
      if (cfg_addr == IDX_OUT_MIN) begin
        min_r <= cfg_wdata;
      end
      if (cfg_addr == IDX_OUT_MAX) begin
        max_r <= cfg_wdata;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused although the result side is not stalled");

  a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == min_r) ||
                   ((out_tdata >= min_r) && (out_tdata <= max_r)))
    else $error("drive outside the clamp bounds");

endmodule

bind incremental_pid_clamped ipid_checker u_ipid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we),
  .cfg_addr   (cfg_addr),
  .cfg_wdata  (cfg_wdata)
);
